/* sv/assert_macros.svh */
// Assertion macros used by the checker file ggc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define GGC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that also holds during reset.
`define GGC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

/* sv/ggc_pkg.sv */
// Types and constants shared by the greedy coloring core.
package ggc_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int VID_W        = 10;
    localparam int CNT_W        = 11;
    localparam int ROW_BITS     = 32;
    localparam int ROWS         = MAX_VERTICES / ROW_BITS;
    localparam int ROW_W        = 5;
    localparam int BIT_W        = 5;
    localparam int FUNC_W       = 2;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 32;

    localparam logic [FUNC_W-1:0] FUNC_NEIGHBOUR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART   = 2'd2;

    typedef enum logic [1:0] {
        OP_MARK    = 2'd0,
        OP_CLOSE   = 2'd1,
        OP_RESTART = 2'd2
    } t_op_kind;

    typedef struct packed {
        t_op_kind               kind;
        logic [VID_W-1:0]       id;
        logic [CNT_W-1:0]       count;
        logic                   last;
    } t_op;

endpackage

/* sv/ggc_queue.sv */
// Small FIFO of classified requests between front and back.
module ggc_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  ggc_pkg::t_op    i_push_op,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output ggc_pkg::t_op    o_pop_op
);
    import ggc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op            r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_fill;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_fill != CW'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_op     = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + CW'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - CW'(1);
            end
        end
    end

endmodule

/* sv/ggc_front.sv */
// Front end: accept input requests, track the current vertex, classify or drop.
module ggc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ggc_pkg::CNT_W-1:0]       i_vertex_count,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ggc_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [9:0] neighbour
    input  logic [ggc_pkg::FUNC_W-1:0]      s_axis_tuser,   // [1:0] func
    output logic                            o_push_valid,
    input  logic                            i_push_ready,
    output ggc_pkg::t_op                    o_push_op
);
    import ggc_pkg::*;

    logic [CNT_W-1:0]   r_cur;
    logic [CNT_W-1:0]   count;
    logic [VID_W-1:0]   nb;
    logic               open;
    logic               keep;
    logic               accept;

    assign nb            = s_axis_tdata[VID_W-1:0];
    assign open          = (r_cur < count);
    assign s_axis_tready = i_push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_push_valid  = s_axis_tvalid && keep;

    always_comb begin
        priority if (i_vertex_count == '0) begin
            count = CNT_W'(1);
        end else if (i_vertex_count > CNT_W'(MAX_VERTICES)) begin
            count = CNT_W'(MAX_VERTICES);
        end else begin
            count = i_vertex_count;
        end
    end

    always_comb begin
        o_push_op.count = count;
        o_push_op.last  = ((r_cur + CNT_W'(1)) == count);
        o_push_op.id    = nb;
        o_push_op.kind  = OP_MARK;
        keep            = 1'b0;
        case (s_axis_tuser)
            FUNC_NEIGHBOUR: begin
                keep = open && ({1'b0, nb} < r_cur);
            end
            FUNC_CLOSE: begin
                keep           = open;
                o_push_op.kind = OP_CLOSE;
                o_push_op.id   = r_cur[VID_W-1:0];
            end
            FUNC_RESTART: begin
                keep           = 1'b1;
                o_push_op.kind = OP_RESTART;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (accept) begin
            if (s_axis_tuser == FUNC_RESTART) begin
                r_cur <= '0;
            end else if (s_axis_tuser == FUNC_CLOSE && open) begin
                r_cur <= r_cur + CNT_W'(1);
            end
        end
    end

endmodule

/* sv/ggc_back.sv */
// Back end: color store, taken-color rows, first-fit search and result register.
module ggc_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_op_valid,
    output logic                            o_op_ready,
    input  ggc_pkg::t_op                    i_op,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ggc_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [9:0] vertex, [20:10] color,
                                                            // [31:21] colors_used
    output logic                            m_axis_tlast
);
    import ggc_pkg::*;

    logic [CNT_W-1:0]       r_cs [MAX_VERTICES];
    logic [CNT_W-1:0]       r_cs_rd;
    logic [ROW_BITS-1:0]    r_mk [ROWS];
    logic [ROW_BITS-1:0]    r_mk_rd;
    logic                   r_mk_rd_vld;
    logic [ROWS-1:0]        r_row_vld;
    logic [ROWS-1:0]        r_row_full;

    logic                   r_b_vld;
    logic                   r_b_close;
    logic [VID_W-1:0]       r_b_id;
    logic [CNT_W-1:0]       r_b_count;
    logic                   r_b_last;
    logic [ROW_W-1:0]       r_b_row;
    logic                   r_b_any_free;

    logic                   r_c_vld;
    logic [ROW_W-1:0]       r_c_row;
    logic [BIT_W-1:0]       r_c_bit;

    logic                   r_fw_vld;
    logic [ROW_W-1:0]       r_fw_row;
    logic [ROW_BITS-1:0]    r_fw_data;

    logic                   r_out_vld;
    logic [M_TDATA_W-1:0]   r_out_data;
    logic                   r_out_last;
    logic [CNT_W-1:0]       r_max_color;

    logic                   out_pop;
    logic                   issue_ok;
    logic                   issue;
    logic                   b_close;
    logic                   b_mark;
    logic [VID_W-1:0]       b_cm1;
    logic                   b_hit;
    logic [ROW_W-1:0]       free_row;
    logic                   free_any;
    logic [ROW_W-1:0]       mk_raddr;
    logic [ROW_BITS-1:0]    c_base;
    logic [ROW_BITS-1:0]    c_new;
    logic [ROW_BITS-1:0]    b_data;
    logic [BIT_W-1:0]       b_zero_bit;
    logic [CNT_W-1:0]       c_raw;
    logic [CNT_W-1:0]       color;
    logic [CNT_W-1:0]       n_max_color;
    logic                   clear_marks;

    assign out_pop = r_out_vld && m_axis_tready;
    assign b_close = r_b_vld && r_b_close;
    assign b_mark  = r_b_vld && !r_b_close;

    always_comb begin
        case (i_op.kind)
            OP_MARK:    issue_ok = !b_close;
            OP_CLOSE:   issue_ok = !r_b_vld && !r_c_vld && (!r_out_vld || out_pop);
            OP_RESTART: issue_ok = !r_b_vld && !r_c_vld;
            default:    issue_ok = 1'b0;
        endcase
    end

    assign o_op_ready  = issue_ok;
    assign issue       = i_op_valid && issue_ok;
    assign clear_marks = b_close || (issue && i_op.kind == OP_RESTART);

    assign b_cm1 = r_cs_rd[VID_W-1:0] - VID_W'(1);
    assign b_hit = (r_cs_rd != '0) && (r_cs_rd <= CNT_W'(MAX_VERTICES));

    always_comb begin
        free_row = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (!r_row_full[i]) begin
                free_row = ROW_W'(i);
            end
        end
    end

    assign free_any = !(&r_row_full);
    assign mk_raddr = b_mark ? b_cm1[VID_W-1:BIT_W] : free_row;

    always_comb begin
        if (r_fw_vld && r_fw_row == r_c_row) begin
            c_base = r_fw_data;
        end else begin
            c_base = r_mk_rd_vld ? r_mk_rd : '0;
        end
        c_new = c_base | (ROW_BITS'(1) << r_c_bit);
    end

    always_comb begin
        b_data     = r_mk_rd_vld ? r_mk_rd : '0;
        b_zero_bit = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (!b_data[i]) begin
                b_zero_bit = BIT_W'(i);
            end
        end
        c_raw = {1'b0, r_b_row, b_zero_bit} + CNT_W'(1);
        if (!r_b_any_free || c_raw > r_b_count) begin
            color = r_b_count;
        end else begin
            color = c_raw;
        end
        n_max_color = (color > r_max_color) ? color : r_max_color;
    end

    always_ff @(posedge i_clk) begin
        if (b_close) begin
            r_cs[r_b_id] <= color;
        end
        r_cs_rd <= r_cs[i_op.id];
    end

    always_ff @(posedge i_clk) begin
        if (r_c_vld) begin
            r_mk[r_c_row] <= c_new;
        end
        r_mk_rd <= r_mk[mk_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_mk_rd_vld  <= r_row_vld[mk_raddr];
        r_b_id       <= i_op.id;
        r_b_count    <= i_op.count;
        r_b_last     <= i_op.last;
        r_b_row      <= free_row;
        r_b_any_free <= free_any;
        r_c_row      <= b_cm1[VID_W-1:BIT_W];
        r_c_bit      <= b_cm1[BIT_W-1:0];
        r_fw_row     <= r_c_row;
        r_fw_data    <= c_new;
        if (b_close) begin
            r_out_data <= {n_max_color, color, r_b_id};
            r_out_last <= r_b_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld     <= 1'b0;
            r_b_close   <= 1'b0;
            r_c_vld     <= 1'b0;
            r_fw_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_max_color <= '0;
            r_row_vld   <= '0;
            r_row_full  <= '0;
        end else begin
            r_b_vld   <= issue && (i_op.kind != OP_RESTART);
            r_b_close <= (i_op.kind == OP_CLOSE);
            r_c_vld   <= b_mark && b_hit;
            r_fw_vld  <= r_c_vld;
            if (clear_marks) begin
                r_row_vld  <= '0;
                r_row_full <= '0;
            end else if (r_c_vld) begin
                r_row_vld[r_c_row]  <= 1'b1;
                r_row_full[r_c_row] <= &c_new;
            end
            if (issue && i_op.kind == OP_RESTART) begin
                r_max_color <= '0;
            end else if (b_close) begin
                r_max_color <= n_max_color;
            end
            if (b_close) begin
                r_out_vld <= 1'b1;
            end else if (out_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

/* sv/greedy_graph_coloring_core.sv */
// Greedy first-fit graph coloring core: config register, front, queue and back.
// Neighbour requests stream at one per cycle unless the queue fills or a close sits in
// the b stage; each costs a color-store read and a read-modify-write of a 32-bit
// taken-color row through the b, c and forward registers. A close waits for in-flight
// marks and the output register to clear; its result goes via the b stage to the output.
// Reset is synchronous: it clears the vertex counter, max color, row valid bits and
// output valid at once; the color store holds no reset and its contents are only used once written.
module greedy_graph_coloring_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ggc_pkg::CNT_W-1:0]       i_cfg_wr_data,  // vertex_count
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ggc_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [9:0] neighbour, [15:10] zero
    input  logic [ggc_pkg::FUNC_W-1:0]      s_axis_tuser,   // [1:0] func
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ggc_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [9:0] vertex, [20:10] color,
                                                            // [31:21] colors_used
    output logic                            m_axis_tlast
);
    import ggc_pkg::*;

    logic [CNT_W-1:0]   r_vertex_count;
    logic               push_valid;
    logic               push_ready;
    t_op                push_op;
    logic               pop_valid;
    logic               pop_ready;
    t_op                pop_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= CNT_W'(MAX_VERTICES);
        end else if (i_cfg_wr_en) begin
            r_vertex_count <= i_cfg_wr_data;
        end
    end

    ggc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_count (r_vertex_count),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_op      (push_op)
    );

    ggc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_op    (push_op),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_op     (pop_op)
    );

    ggc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_valid    (pop_valid),
        .o_op_ready    (pop_ready),
        .i_op          (pop_op),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* sv/ggc_checker.sv */
// Port-level checker for the greedy coloring core, bound to the top level.
`include "assert_macros.svh"

module ggc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [ggc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                            m_axis_tlast
);
    import ggc_pkg::*;

    logic [VID_W-1:0] vertex;
    logic [CNT_W-1:0] color;
    logic [CNT_W-1:0] used;

    assign vertex = m_axis_tdata[VID_W-1:0];
    assign color  = m_axis_tdata[VID_W+CNT_W-1:VID_W];
    assign used   = m_axis_tdata[VID_W+2*CNT_W-1:VID_W+CNT_W];

    `GGC_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `GGC_ASSERT(a_color_le_used, i_clk, i_rst_n, m_axis_tvalid |-> color != '0 && color <= used)
    `GGC_ASSERT(a_color_bound, i_clk, i_rst_n, m_axis_tvalid |-> color <= ({1'b0, vertex} + CNT_W'(1)))
    `GGC_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind greedy_graph_coloring_core ggc_checker u_ggc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* tb/ggc_color_checker.sv */
// Stream monitor for the greedy coloring core: predicts each coloring and compares results.
module ggc_color_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ggc_pkg::CNT_W-1:0]       i_cfg_wr_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [ggc_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [9:0] neighbour, [15:10] zero
    input  logic [ggc_pkg::FUNC_W-1:0]      s_axis_tuser,   // [1:0] func
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [ggc_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [9:0] vertex, [20:10] color,
                                                            // [31:21] colors_used
    input  logic                            m_axis_tlast,
    output int                              o_pending,
    output int                              o_colored,
    output int                              o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ggc_pkg::*;

    typedef struct packed {
        logic [VID_W-1:0] vertex;
        logic [CNT_W-1:0] color;
        logic [CNT_W-1:0] colors_used;
        logic             last;
    } coloring_t;

    logic [CNT_W-1:0]      color_of [MAX_VERTICES];
    logic [MAX_VERTICES:0] taken;
    logic [CNT_W-1:0]      next_vertex;
    logic [CNT_W-1:0]      top_color;
    logic [CNT_W-1:0]      vertex_count;
    coloring_t             expected_colorings [$];
    int                    shown;

    function automatic logic [CNT_W-1:0] clamped_count(input logic [CNT_W-1:0] raw);
        if (raw == '0) begin
            return CNT_W'(1);
        end
        if (raw > MAX_VERTICES) begin
            return CNT_W'(MAX_VERTICES);
        end
        return raw;
    endfunction

    task automatic apply_request(input logic [FUNC_W-1:0] fn, input logic [VID_W-1:0] nb);
        logic [CNT_W-1:0] limit;
        int               c;
        coloring_t        res;
        limit = clamped_count(vertex_count);
        if (fn == FUNC_RESTART) begin
            next_vertex = '0;
            top_color   = '0;
            taken       = '0;
            return;
        end
        if (next_vertex >= limit) begin
            return;
        end
        if (fn == FUNC_NEIGHBOUR) begin
            if (CNT_W'(nb) < next_vertex && color_of[nb] >= 1 && color_of[nb] <= MAX_VERTICES) begin
                taken[color_of[nb]] = 1'b1;
            end
        end else if (fn == FUNC_CLOSE) begin
            c = 1;
            while (c <= limit && taken[c]) begin
                c++;
            end
            if (c > limit) begin
                c = limit;
            end
            color_of[next_vertex[VID_W-1:0]] = CNT_W'(c);
            taken = '0;
            if (CNT_W'(c) > top_color) begin
                top_color = CNT_W'(c);
            end
            res.vertex      = next_vertex[VID_W-1:0];
            res.color       = CNT_W'(c);
            res.colors_used = top_color;
            res.last        = (next_vertex + 1'b1 == limit);
            expected_colorings.push_back(res);
            next_vertex++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        coloring_t got;
        coloring_t want;
        if (!i_rst_n) begin
            vertex_count = CNT_W'(MAX_VERTICES);
            next_vertex  = '0;
            top_color    = '0;
            taken        = '0;
            expected_colorings.delete();
            shown        = 0;
            o_colored    = 0;
            o_fail_count = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.vertex      = m_axis_tdata[VID_W-1:0];
                got.color       = m_axis_tdata[VID_W +: CNT_W];
                got.colors_used = m_axis_tdata[VID_W+CNT_W +: CNT_W];
                got.last        = m_axis_tlast;
                if (expected_colorings.size() == 0) begin
                    o_fail_count++;
                    if (shown < 10) begin
                        shown++;
                        $display("%0t: unexpected result vertex %0d color %0d used %0d last %0b",
                                 $realtime, got.vertex, got.color, got.colors_used, got.last);
                    end
                end else begin
                    want = expected_colorings.pop_front();
                    o_colored++;
                    if (got !== want) begin
                        o_fail_count++;
                        if (shown < 10) begin
                            shown++;
                            $display("%0t: mismatch vertex exp %0d got %0d, color exp %0d got %0d",
                                     $realtime, want.vertex, got.vertex, want.color, got.color);
                            $display("    colors_used exp %0d got %0d, last exp %0b got %0b",
                                     want.colors_used, got.colors_used, want.last, got.last);
                        end
                    end
                end
            end
            if (i_cfg_wr_en) begin
                vertex_count = i_cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(s_axis_tuser, s_axis_tdata[VID_W-1:0]);
            end
        end
        o_pending = expected_colorings.size();
    end

endmodule

/* tb/greedy_graph_coloring_core_tb.sv */
// Testbench top for the greedy coloring core: clock, reset, request stimulus and verdict.
module greedy_graph_coloring_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ggc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_REQS    = 115;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_wr_en    = 1'b0;
    logic [CNT_W-1:0]       i_cfg_wr_data  = '0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata   = '0;   // [9:0] neighbour, [15:10] zero
    logic [FUNC_W-1:0]      s_axis_tuser   = '0;   // [1:0] func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;          // [9:0] vertex, [20:10] color,
                                                   // [31:21] colors_used
    logic                   m_axis_tlast;

    int pending;
    int colored;
    int fail_count;
    int send_gap_pct  = 0;
    int stall_pct     = 0;
    int stim_next     = 0;
    int stim_limit    = MAX_VERTICES;
    int req_count     = 0;
    int setting_count = 0;
    int cycle_count   = 0;

    greedy_graph_coloring_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ggc_color_checker color_watch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_pending     (pending),
        .o_colored     (colored),
        .o_fail_count  (fail_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [VID_W-1:0] nb);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {{(S_TDATA_W-VID_W){1'b0}}, nb};
        do @(posedge i_clk); while (!s_axis_tready);
        req_count++;
        if (fn == FUNC_RESTART) begin
            stim_next = 0;
        end else if (fn == FUNC_CLOSE && stim_next < stim_limit) begin
            stim_next++;
        end
    endtask

    // drop valid and hold until every coloring is out and the marks have drained
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        settle_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        stim_limit = (value == 0) ? 1 : (value > MAX_VERTICES) ? MAX_VERTICES : value;
        setting_count++;
    endtask

    task automatic color_graph(input bit dense, input bit fresh, input int max_nb,
                               input int stop_at);
        int j;
        if (fresh) begin
            send_request(FUNC_RESTART, VID_W'($urandom_range(0, 1023)));
        end
        while (stim_next < stim_limit && req_count < stop_at) begin
            if (dense) begin
                for (j = stim_next - 1; j >= 0; j--) begin
                    if ($urandom_range(0, 4) != 0) begin
                        send_request(FUNC_NEIGHBOUR, VID_W'(j));
                    end
                end
            end else begin
                repeat ($urandom_range(0, max_nb)) begin
                    send_request(FUNC_NEIGHBOUR, (stim_next > 0) ?
                                 VID_W'($urandom_range(0, stim_next - 1)) :
                                 VID_W'($urandom_range(0, 1023)));
                end
            end
            if ($urandom_range(0, 99) < 8) begin
                case ($urandom_range(0, 3))
                    0: send_request(FUNC_UNUSED, VID_W'($urandom_range(0, 1023)));
                    1: send_request(FUNC_NEIGHBOUR, VID_W'($urandom_range(stim_next, 1023)));
                    2: send_request(FUNC_NEIGHBOUR, VID_W'($urandom_range(0, 1023)));
                    default: send_request(FUNC_RESTART, VID_W'($urandom_range(0, 1023)));
                endcase
            end
            send_request(FUNC_CLOSE, VID_W'($urandom_range(0, 1023)));
        end
        repeat ($urandom_range(0, 2)) begin
            send_request($urandom_range(0, 1) ? FUNC_CLOSE : FUNC_NEIGHBOUR,
                         VID_W'($urandom_range(0, 1023)));
        end
    endtask

    initial begin
        int phase;
        int stop_at;
        bit dense;
        logic [CNT_W-1:0] count;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // build a small graph at the reset count, then shrink the count mid graph
        send_request(FUNC_CLOSE, 10'h3FF);
        send_request(FUNC_NEIGHBOUR, 10'd0);
        send_request(FUNC_CLOSE, 10'd0);
        send_request(FUNC_NEIGHBOUR, 10'd1);
        send_request(FUNC_NEIGHBOUR, 10'd0);
        send_request(FUNC_NEIGHBOUR, 10'd1);
        send_request(FUNC_NEIGHBOUR, 10'd2);
        send_request(FUNC_NEIGHBOUR, 10'h3FF);
        send_request(FUNC_CLOSE, 10'd0);
        send_request(FUNC_UNUSED, 10'h3FF);
        send_request(FUNC_NEIGHBOUR, 10'd0);
        send_request(FUNC_CLOSE, 10'd0);
        write_count(11'd5);
        send_request(FUNC_NEIGHBOUR, 10'd3);
        send_request(FUNC_NEIGHBOUR, 10'd2);
        send_request(FUNC_NEIGHBOUR, 10'd1);
        send_request(FUNC_CLOSE, 10'd0);
        send_request(FUNC_CLOSE, 10'd0);
        send_request(FUNC_NEIGHBOUR, 10'd0);
        write_count(11'd0);
        send_request(FUNC_RESTART, 10'd0);
        send_request(FUNC_CLOSE, 10'd0);
        send_request(FUNC_CLOSE, 10'd0);
        write_count(11'h7FF);
        send_request(FUNC_RESTART, 10'h155);
        send_request(FUNC_NEIGHBOUR, 10'h2AA);
        send_request(FUNC_CLOSE, 10'd0);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 45; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 45; end
                default: begin send_gap_pct = 31; stall_pct = 31; end
            endcase
            stop_at = req_count + PHASE_REQS;
            while (req_count < stop_at) begin
                dense = ($urandom_range(0, 2) == 0);
                if (dense) begin
                    count = CNT_W'($urandom_range(2, 20));
                end else begin
                    case ($urandom_range(0, 9))
                        0: count = '0;
                        1: count = CNT_W'($urandom_range(1025, 2047));
                        default: count = CNT_W'($urandom_range(1, 40));
                    endcase
                end
                write_count(count);
                color_graph(dense, $urandom_range(0, 99) >= 15, 3, stop_at);
            end
        end

        stall_pct = 0;
        settle_idle();
        $display("Sent %0d requests and checked %0d colorings across %0d vertex-count settings,",
                 req_count, colored, setting_count);
        $display("with dense and sparse graphs under four sender/receiver idle patterns.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d colorings outstanding", cycle_count, pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
